/* hdl/number_to_english_words_macros.svh */
// Assertion shorthands used by the RTL.
`ifndef NUMBER_TO_ENGLISH_WORDS_MACROS_SVH
`define NUMBER_TO_ENGLISH_WORDS_MACROS_SVH

// Check that the consequent holds in the same cycle.
`define NTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the next cycle.
`define NTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/nte_pkg.sv */
`timescale 1ns / 1ps
package nte_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int WORD_BITS      = 5;
  localparam int BCD_DIGITS     = 12;
  localparam int BCD_BITS       = 4 * BCD_DIGITS;
  localparam int GRP_BITS       = 12;

  localparam logic [WORD_BITS-1:0] W_ZERO    = 5'd0;
  localparam logic [WORD_BITS-1:0] W_TEN     = 5'd10;
  localparam logic [WORD_BITS-1:0] W_TWENTY  = 5'd20;
  localparam logic [WORD_BITS-1:0] W_HUNDRED = 5'd28;

  typedef struct packed {
    logic load;
    logic dabble;
    logic next_grp;
  } nte_bcd_ctl_t;

endpackage

/* hdl/nte_in_if.sv */
`timescale 1ns / 1ps
interface nte_in_if import nte_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* hdl/nte_out_if.sv */
`timescale 1ns / 1ps
interface nte_out_if import nte_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] word_code;
  logic                 last_word;

  modport source (output valid, output word_code, output last_word, input ready);
  modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

/* hdl/nte_bcd.sv */
`timescale 1ns / 1ps
module nte_bcd import nte_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  nte_bcd_ctl_t          ctl,
  input  logic [VALUE_BITS-1:0] value,
  output logic [BCD_BITS-1:0]   bcd_r
);

  logic [VALUE_BITS-1:0] bin_r;
  logic [VALUE_BITS-1:0] bin_nxt;
  logic [BCD_BITS-1:0]   bcd_nxt;
  logic [BCD_BITS-1:0]   adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.load) begin
      bin_nxt = value;
      bcd_nxt = '0;
    end else if (ctl.dabble) begin
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {adj[BCD_BITS-2:0], bin_r[VALUE_BITS-1]};
    end else if (ctl.next_grp) begin
      bcd_nxt = {bcd_r[BCD_BITS-GRP_BITS-1:0], {GRP_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

endmodule

/* hdl/number_to_english_words.sv */
`timescale 1ns / 1ps
// Spells a non-negative number as English word codes, one word per output
// handshake, last_word high on the final one. A small microcode program
// steps one control word per cycle, holding its step while a word waits on
// a stalled output: one accept step, VALUE_BITS steps of shift-add-3
// decimal conversion, one zero check, then five steps for each of the four
// digit groups (billions, millions, thousands, units); a zero ends after
// the zero check. One number is worked at a time; a new one is taken only
// at the accept step, while the last word may still sit in the output
// register.
`include "number_to_english_words_macros.svh"
module number_to_english_words import nte_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  nte_in_if.sink           in_word,
  nte_out_if.source        out_word
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam logic [1:0] GRP_TOP = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_ZCHK, S_HDIG, S_HWORD, S_TENS, S_UNITS, S_SCALE
  } step_t;

  typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_DABBLE, OP_NEXT} op_t;

  typedef enum logic [2:0] {
    E_NONE, E_ZERO, E_HDIG, E_HUNDRED, E_TENS, E_UNITS, E_SCALE
  } emit_t;

  typedef enum logic [2:0] {
    C_NEVER, C_NO_INPUT, C_CNT_MORE, C_BCD_ZERO, C_GRP_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    emit_t emit;
    cond_t cond;
    step_t target;
  } cw_t;

  function automatic cw_t ucode(input step_t pc);
    cw_t cw;
    unique case (pc)
      S_IDLE:  cw = '{OP_LOAD,   E_NONE,    C_NO_INPUT, S_IDLE};
      S_CONV:  cw = '{OP_DABBLE, E_NONE,    C_CNT_MORE, S_CONV};
      S_ZCHK:  cw = '{OP_NONE,   E_ZERO,    C_BCD_ZERO, S_IDLE};
      S_HDIG:  cw = '{OP_NONE,   E_HDIG,    C_NEVER,    S_IDLE};
      S_HWORD: cw = '{OP_NONE,   E_HUNDRED, C_NEVER,    S_IDLE};
      S_TENS:  cw = '{OP_NONE,   E_TENS,    C_NEVER,    S_IDLE};
      S_UNITS: cw = '{OP_NONE,   E_UNITS,   C_NEVER,    S_IDLE};
      S_SCALE: cw = '{OP_NEXT,   E_SCALE,   C_GRP_MORE, S_HDIG};
      default: cw = '{OP_NONE,   E_NONE,    C_NEVER,    S_IDLE};
    endcase
    return cw;
  endfunction

  step_t                pc_r, pc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           grp_r, grp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_code_r, out_code_nxt;
  logic                 out_last_r, out_last_nxt;

  cw_t                  cw;
  nte_bcd_ctl_t         bcd_ctl;
  logic [BCD_BITS-1:0]  bcd;
  logic [3:0]           dig_h, dig_t, dig_u;
  logic                 low_zero;
  logic                 applies, last, jump, slot_free, stall, emit_go;
  logic [WORD_BITS-1:0] code;

  assign cw       = ucode(pc_r);
  assign dig_h    = bcd[BCD_BITS-1 -: 4];
  assign dig_t    = bcd[BCD_BITS-5 -: 4];
  assign dig_u    = bcd[BCD_BITS-9 -: 4];
  assign low_zero = (bcd[BCD_BITS-GRP_BITS-1:0] == '0);

  always_comb begin
    applies = 1'b0;
    last    = 1'b0;
    code    = W_ZERO;
    unique case (cw.emit)
      E_NONE: ;
      E_ZERO: begin
        applies = (bcd == '0);
        last    = 1'b1;
      end
      E_HDIG: begin
        applies = (dig_h != 4'd0);
        code    = WORD_BITS'(dig_h);
      end
      E_HUNDRED: begin
        applies = (dig_h != 4'd0);
        code    = W_HUNDRED;
        last    = (grp_r == 2'd0) && (dig_t == 4'd0) && (dig_u == 4'd0);
      end
      E_TENS: begin
        applies = (dig_t != 4'd0);
        code    = (dig_t == 4'd1) ? W_TEN + WORD_BITS'(dig_u)
                                  : W_TWENTY + WORD_BITS'(dig_t) - 5'd2;
        last    = (grp_r == 2'd0) && ((dig_t == 4'd1) || (dig_u == 4'd0));
      end
      E_UNITS: begin
        applies = (dig_t != 4'd1) && (dig_u != 4'd0);
        code    = WORD_BITS'(dig_u);
        last    = (grp_r == 2'd0);
      end
      E_SCALE: begin
        applies = (grp_r != 2'd0) && (bcd[BCD_BITS-1 -: GRP_BITS] != '0);
        code    = W_HUNDRED + WORD_BITS'(grp_r);
        last    = low_zero;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_INPUT: jump = !in_word.valid;
      C_CNT_MORE: jump = (cnt_r != CNT_W'(1));
      C_BCD_ZERO: jump = (bcd == '0);
      C_GRP_MORE: jump = (grp_r != 2'd0);
      default:    jump = 1'b0;
    endcase
  end

  assign slot_free = !out_valid_r || out_word.ready;
  assign stall     = applies && !slot_free;
  assign emit_go   = applies && slot_free;

  assign bcd_ctl.load     = (cw.op == OP_LOAD) && in_word.valid;
  assign bcd_ctl.dabble   = (cw.op == OP_DABBLE);
  assign bcd_ctl.next_grp = (cw.op == OP_NEXT) && !stall;

  nte_bcd #(.VALUE_BITS(VALUE_BITS)) u_bcd (
    .clk   (clk),
    .ctl   (bcd_ctl),
    .value (in_word.value),
    .bcd_r (bcd)
  );

  always_comb begin
    pc_nxt        = stall ? pc_r : (jump ? cw.target : step_t'(pc_r + 3'd1));
    cnt_nxt       = cnt_r;
    grp_nxt       = grp_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    if (bcd_ctl.load) begin
      cnt_nxt = CNT_W'(VALUE_BITS);
      grp_nxt = GRP_TOP;
    end else if (bcd_ctl.dabble) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (bcd_ctl.next_grp) begin
      grp_nxt = grp_r - 2'd1;
    end
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = code;
      out_last_nxt  = last;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      cnt_r       <= '0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_word.ready      = (cw.op == OP_LOAD);
  assign out_word.valid     = out_valid_r;
  assign out_word.word_code = out_code_r;
  assign out_word.last_word = out_last_r;

  `NTE_ASSERT_NXT(a_load_starts, in_word.valid && in_word.ready, pc_r == S_CONV && grp_r == GRP_TOP && cnt_r == CNT_W'(VALUE_BITS), "accept did not start conversion")
  `NTE_ASSERT_IMP(a_zchk_after_conv, pc_r == S_ZCHK, $past(pc_r) == S_ZCHK || ($past(pc_r) == S_CONV && $past(cnt_r) == CNT_W'(1)), "zero check reached early")
  `NTE_ASSERT_IMP(a_zero_alone, out_valid_r && out_code_r == W_ZERO, out_last_r, "zero word not marked last")
  `NTE_ASSERT_IMP(a_emit_room, emit_go, !out_valid_r || out_word.ready, "word overwrote a pending word")

endmodule
